>>> rtl/core/http_chunked_decoder_defines.svh
// Assertion macros shared by the chunked decoder RTL.
`ifndef HTTP_CHUNKED_DECODER_DEFINES_SVH
`define HTTP_CHUNKED_DECODER_DEFINES_SVH

// Same-cycle implication, sampled on clk, off while arst_n is low.
`define HCD_ASSERT_NOW(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, sampled on clk, off while arst_n is low.
`define HCD_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

>>> rtl/core/hcd_pkg.sv
// Shared constants, result type and nibble rule for the chunked decoder.
package hcd_pkg;

	localparam logic [7:0] BYTE_LF   = 8'd10;
	localparam logic [7:0] BYTE_CR   = 8'd13;
	localparam logic [7:0] BYTE_SEMI = 8'd59;

	typedef struct packed {
		logic       body_done;
		logic       payload_valid;
		logic [7:0] payload_byte;
	} hcd_result_t;

	// Loose hex rule: (b & 15) + (b >> 6) * 9, kept to 4 bits.
	function automatic logic [3:0] hex_nibble(input logic [7:0] b);
		logic [7:0] sum;
		sum = 8'(b[3:0]) + 8'(b[7:6]) * 8'd9;
		return sum[3:0];
	endfunction

endpackage

>>> rtl/core/http_chunked_decoder.sv
// Top level of the HTTP chunked transfer body decoder.
// Usage:
//   Slave stream s_axis_*: one raw body byte per transfer in tdata, tlast set
//   on the final byte of a body. After that byte the parser restarts at the
//   size line of a fresh body.
//   Master stream m_axis_*: exactly one result transfer per input byte.
//   tdata carries the payload byte (zero when it is not payload), tuser[0]
//   marks a payload byte, tuser[1] reports that the zero-size line has ended.
// Pipeline: two register stages, input register then result register.
// Throughput: one byte per clock while m_axis_tready is high; the parse
//   step is a single pass of compare, shift-in and decrement logic
//   between the two registers.
// Reset: arst_n clears both stages and returns the parser to digit mode
//   with a zero chunk count.
// Stall: while m_axis_tready is low the result is held, the input register
//   fills, and then s_axis_tready drops; no transfer is lost or repeated.
module http_chunked_decoder #(
	parameter int SIZE_BITS = 32
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       s_axis_tvalid,
	output logic       s_axis_tready,
	input  logic [7:0] s_axis_tdata,  // [7:0] data_byte
	input  logic       s_axis_tlast,  // last_byte
	output logic       m_axis_tvalid,
	input  logic       m_axis_tready,
	output logic [7:0] m_axis_tdata,  // [7:0] payload_byte
	output logic [1:0] m_axis_tuser   // [0] payload_valid, [1] body_done
);
	import hcd_pkg::*;

	`include "http_chunked_decoder_defines.svh"

	// input register
	logic        valid_s1;
	logic [7:0]  data_s1;
	logic        last_s1;

	// result register
	hcd_result_t result_s2;
	logic        valid_s2;

	hcd_result_t step_result;
	logic        advance;

	// item in s1 moves on when the result register is empty or being drained
	assign advance = valid_s1 && (!valid_s2 || m_axis_tready);
	assign s_axis_tready = !valid_s1 || advance;

	hcd_parser #(
		.SIZE_BITS(SIZE_BITS)
	) u_parser (
		.clk      (clk),
		.arst_n   (arst_n),
		.step     (advance),
		.data_byte(data_s1),
		.last_byte(last_s1),
		.result   (step_result)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_axis_tready) begin
			valid_s1 <= s_axis_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_axis_tready && s_axis_tvalid) begin
			data_s1 <= s_axis_tdata;
			last_s1 <= s_axis_tlast;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (advance) begin
			valid_s2 <= 1'b1;
		end else if (m_axis_tready) begin
			valid_s2 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			result_s2 <= step_result;
		end
	end

	assign m_axis_tvalid = valid_s2;
	assign m_axis_tdata = result_s2.payload_byte;
	assign m_axis_tuser = {result_s2.body_done, result_s2.payload_valid};

	`HCD_ASSERT_NOW(a_zero_fill, m_axis_tvalid && !m_axis_tuser[0], m_axis_tdata == 8'd0, "non-payload result carries data")
	`HCD_ASSERT_NOW(a_done_excl, m_axis_tvalid, !(m_axis_tuser[0] && m_axis_tuser[1]), "payload byte flagged after body end")
	`HCD_ASSERT_NEXT(a_s1_hold, valid_s1 && !advance, valid_s1 && $stable(data_s1) && $stable(last_s1), "input register lost a byte")
	`HCD_ASSERT_NEXT(a_result_load, advance, m_axis_tvalid, "step did not load result register")

endmodule

>>> rtl/core/hcd_parser.sv
// Parse state of the chunked decoder: mode, chunk count and one-byte step.
module hcd_parser #(
	parameter int SIZE_BITS = 32
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                step,
	input  logic [7:0]          data_byte,
	input  logic                last_byte,
	output hcd_pkg::hcd_result_t result
);
	import hcd_pkg::*;

	typedef enum logic [2:0] {
		MODE_DIGITS,
		MODE_SKIP_SIZE,
		MODE_DATA,
		MODE_SKIP_DATA,
		MODE_DONE
	} mode_t;

	mode_t                mode_q, mode_d;
	logic [SIZE_BITS-1:0] count_q, count_d;
	logic                 is_lf, is_stop;

	assign is_lf   = (data_byte == BYTE_LF);
	assign is_stop = (data_byte == BYTE_CR) || (data_byte == BYTE_SEMI);

	always_comb begin
		mode_d = mode_q;
		count_d = count_q;
		result.payload_valid = 1'b0;
		result.payload_byte = 8'd0;
		case (mode_q)
			MODE_DIGITS: begin
				if (is_lf) begin
					mode_d = (count_q == '0) ? MODE_DONE : MODE_DATA;
				end else if (is_stop) begin
					mode_d = MODE_SKIP_SIZE;
				end else begin
					count_d = {count_q[SIZE_BITS-5:0], hex_nibble(data_byte)};
				end
			end
			MODE_SKIP_SIZE: begin
				if (is_lf) begin
					mode_d = (count_q == '0) ? MODE_DONE : MODE_DATA;
				end
			end
			MODE_DATA: begin
				result.payload_valid = 1'b1;
				result.payload_byte = data_byte;
				count_d = count_q - SIZE_BITS'(1);
				if (count_q == SIZE_BITS'(1)) begin
					mode_d = MODE_SKIP_DATA;
				end
			end
			MODE_SKIP_DATA: begin
				if (is_lf) begin
					mode_d = MODE_DIGITS;
					count_d = '0;
				end
			end
			MODE_DONE: begin
				mode_d = MODE_DONE;
			end
			default: begin
				mode_d = MODE_DIGITS;
				count_d = '0;
			end
		endcase
		// done flag is taken before the end-of-body restart
		result.body_done = (mode_d == MODE_DONE);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q <= MODE_DIGITS;
			count_q <= '0;
		end else if (step) begin
			if (last_byte) begin
				mode_q <= MODE_DIGITS;
				count_q <= '0;
			end else begin
				mode_q <= mode_d;
				count_q <= count_d;
			end
		end
	end

endmodule

>>> test/tb.sv
// Testbench for http_chunked_decoder: predicts each result transfer and checks it.
module tb;
	import hcd_pkg::*;

	localparam int SIZE_BITS    = 32;
	localparam int IDLE_PCT     = 22;        // chance in 100 that a side idles in a cycle
	localparam int DRAIN_CYCLES = 8;         // two register stages, plus margin
	localparam int TIMEOUT      = 4_000_000; // simulation time limit, in time units

	// ASCII anchors for building size lines
	localparam logic [7:0] CH_ZERO = 8'h30;
	localparam logic [7:0] CH_UP_A = 8'h41;
	localparam logic [7:0] CH_LO_A = 8'h61;
	localparam logic [7:0] CH_X    = 8'h78;

	// Parser modes of the predictor; codes 5..7 are never reached
	typedef enum logic [2:0] {
		MODE_DIGITS    = 3'd0,
		MODE_SKIP_SIZE = 3'd1,
		MODE_DATA      = 3'd2,
		MODE_SKIP_DATA = 3'd3,
		MODE_DONE      = 3'd4
	} parse_mode_e;

	logic       clk           = 1'b0;
	logic       arst_n        = 1'b0;
	logic       s_axis_tvalid = 1'b0;
	logic       s_axis_tready;
	logic [7:0] s_axis_tdata  = '0;
	logic       s_axis_tlast  = 1'b0;
	logic       m_axis_tvalid;
	logic       m_axis_tready = 1'b0;
	logic [7:0] m_axis_tdata;
	logic [1:0] m_axis_tuser;

	// Predictor state: parse mode and chunk size / bytes left in the chunk
	parse_mode_e          prs_mode  = MODE_DIGITS;
	logic [SIZE_BITS-1:0] prs_count = '0;

	hcd_result_t pending_results[$]; // expected results, oldest first
	logic [7:0]  body_bytes[$];      // byte sequence being built for the next send

	int  error_count = 0;
	int  items_sent  = 0;
	int  hold_cycles = 0;   // receiver hold-off, counted down in the receiver process
	bit  idle_enable = 1'b1;

	http_chunked_decoder #(
		.SIZE_BITS(SIZE_BITS)
	) u_dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.s_axis_tvalid(s_axis_tvalid),
		.s_axis_tready(s_axis_tready),
		.s_axis_tdata (s_axis_tdata),  // [7:0] data_byte
		.s_axis_tlast (s_axis_tlast),  // last_byte
		.m_axis_tvalid(m_axis_tvalid),
		.m_axis_tready(m_axis_tready),
		.m_axis_tdata (m_axis_tdata),  // [7:0] payload_byte
		.m_axis_tuser (m_axis_tuser)   // [0] payload_valid, [1] body_done
	);

	// 10 time unit clock
	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// ------------------------------------------------------------------
	// Predictor
	// ------------------------------------------------------------------

	// End of a size line: a zero size is the terminating chunk.
	function automatic void close_size_line();
		prs_mode = (prs_count == '0) ? MODE_DONE : MODE_DATA;
	endfunction

	// One byte through the parser; returns the result transfer it causes.
	function automatic hcd_result_t chunk_parse(input logic [7:0] b, input logic last);
		hcd_result_t r;
		logic [3:0]  nib;
		r = '0;
		case (prs_mode)
			MODE_DIGITS: begin
				if (b == BYTE_LF) begin
					close_size_line();
				end else if (b == BYTE_CR || b == BYTE_SEMI) begin
					prs_mode = MODE_SKIP_SIZE;
				end else begin
					// loose hex rule, all in 4 bits so the sum wraps mod 16
					nib = b[3:0] + 4'(b[7:6]) * 4'd9;
					prs_count = {prs_count[SIZE_BITS-5:0], nib};
				end
			end
			MODE_SKIP_SIZE: begin
				if (b == BYTE_LF)
					close_size_line();
			end
			MODE_DATA: begin
				r.payload_valid = 1'b1;
				r.payload_byte  = b;
				prs_count = prs_count - 1'b1;
				if (prs_count == '0)
					prs_mode = MODE_SKIP_DATA;
			end
			MODE_SKIP_DATA: begin
				if (b == BYTE_LF) begin
					prs_mode  = MODE_DIGITS;
					prs_count = '0;
				end
			end
			MODE_DONE: ;
			default: begin
				prs_mode  = MODE_DIGITS;
				prs_count = '0;
			end
		endcase
		// done flag is taken before the end-of-body restart
		r.body_done = (prs_mode == MODE_DONE);
		if (last) begin
			prs_mode  = MODE_DIGITS;
			prs_count = '0;
		end
		return r;
	endfunction

	// ------------------------------------------------------------------
	// Sender side
	// ------------------------------------------------------------------

	// Offers one byte; entered and left at a falling edge. Random idle cycles
	// come first, with junk on the data lines so only tvalid qualifies them.
	task automatic send_byte(input logic [7:0] b, input logic last);
		while (idle_enable && $urandom_range(99) < IDLE_PCT) begin
			s_axis_tvalid <= 1'b0;
			s_axis_tdata  <= 8'($urandom);
			s_axis_tlast  <= 1'($urandom);
			@(negedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tdata  <= b;
		s_axis_tlast  <= last;
		do
			@(posedge clk);
		while (!s_axis_tready);
		// transfer taken at this edge
		pending_results.push_back(chunk_parse(b, last));
		items_sent++;
		@(negedge clk);
	endtask

	// Sends body_bytes; keep > 0 clips it to that many bytes. tlast goes on
	// the final byte sent.
	task automatic send_body(input int keep);
		int n;
		n = (keep > 0 && keep < body_bytes.size()) ? keep : body_bytes.size();
		for (int i = 0; i < n; i++)
			send_byte(body_bytes[i], i == n - 1);
	endtask

	function automatic logic [7:0] hex_char(input logic [3:0] d, input bit upper);
		if (d < 4'd10)
			return CH_ZERO + 8'(d);
		return (upper ? CH_UP_A : CH_LO_A) + 8'(d) - 8'd10;
	endfunction

	// Any byte but LF, for extensions and junk ahead of a line end.
	function automatic logic [7:0] text_byte();
		logic [7:0] b;
		b = 8'($urandom);
		return (b == BYTE_LF) ? CH_X : b;
	endfunction

	// Line end: mostly CR LF, sometimes a bare LF.
	task automatic push_line_end();
		if ($urandom_range(7) != 0)
			body_bytes.push_back(BYTE_CR);
		body_bytes.push_back(BYTE_LF);
	endtask

	// Size line in hex, random case and leading zeros, optional extension.
	task automatic push_size_line(input int unsigned size, input bit ext);
		int nd;
		bit upper;
		upper = 1'($urandom);
		nd = 1;
		repeat ($urandom_range(2))
			body_bytes.push_back(hex_char(4'd0, upper));
		while (nd < 8 && (size >> (4 * nd)) != 0)
			nd++;
		for (int i = nd - 1; i >= 0; i--)
			body_bytes.push_back(hex_char(4'(size >> (4 * i)), upper));
		if (ext) begin
			body_bytes.push_back(BYTE_SEMI);
			repeat ($urandom_range(1, 5))
				body_bytes.push_back(text_byte());
		end
		push_line_end();
	endtask

	// Well-formed body: up to four chunks, zero chunk, optional trailer junk.
	task automatic build_body();
		int size;
		body_bytes.delete();
		repeat ($urandom_range(4)) begin
			size = ($urandom_range(9) == 0) ? $urandom_range(17, 64) : $urandom_range(1, 16);
			push_size_line(size, $urandom_range(3) == 0);
			repeat (size)
				body_bytes.push_back(8'($urandom));
			if ($urandom_range(5) == 0)
				repeat ($urandom_range(1, 3))
					body_bytes.push_back(text_byte());
			push_line_end();
		end
		push_size_line(0, $urandom_range(3) == 0);
		if ($urandom_range(2) == 0) begin
			repeat ($urandom_range(1, 10))
				body_bytes.push_back(8'($urandom));
			push_line_end();
		end
		push_line_end();
	endtask

	// Mostly good bodies; some clipped by an early tlast, some raw noise
	// with LFs mixed in so empty and odd size lines show up.
	task automatic send_mix(input int n_items);
		int stop;
		int kind;
		stop = items_sent + n_items;
		while (items_sent < stop) begin
			kind = $urandom_range(99);
			if (kind < 80) begin
				build_body();
				send_body(0);
			end else if (kind < 90) begin
				build_body();
				send_body($urandom_range(1, body_bytes.size()));
			end else begin
				body_bytes.delete();
				repeat ($urandom_range(1, 20))
					body_bytes.push_back(($urandom_range(5) == 0) ? BYTE_LF : 8'($urandom));
				send_body(0);
			end
		end
	endtask

	// ------------------------------------------------------------------
	// Receiver side
	// ------------------------------------------------------------------

	// tready: random idling, or held low while a hold-off is counting down.
	always @(negedge clk) begin
		if (hold_cycles > 0) begin
			m_axis_tready <= 1'b0;
			hold_cycles = hold_cycles - 1;
		end else begin
			m_axis_tready <= !idle_enable || ($urandom_range(99) >= IDLE_PCT);
		end
	end

	task automatic report_mismatch(input string msg);
		$display("MISMATCH @%0t: %s", $realtime, msg);
		error_count++;
	endtask

	// Every result transfer against the oldest expectation.
	always @(posedge clk) begin : check_results
		hcd_result_t want;
		if (arst_n && m_axis_tvalid && m_axis_tready) begin
			if (pending_results.size() == 0) begin
				report_mismatch($sformatf("unexpected result tdata=%02h tuser=%b",
					m_axis_tdata, m_axis_tuser));
			end else begin
				want = pending_results.pop_front();
				if (m_axis_tuser[0] !== want.payload_valid)
					report_mismatch($sformatf("payload_valid got %b want %b",
						m_axis_tuser[0], want.payload_valid));
				if (m_axis_tdata !== want.payload_byte)
					report_mismatch($sformatf("payload_byte got %02h want %02h",
						m_axis_tdata, want.payload_byte));
				if (m_axis_tuser[1] !== want.body_done)
					report_mismatch($sformatf("body_done got %b want %b",
						m_axis_tuser[1], want.body_done));
			end
		end
	end

	// ------------------------------------------------------------------
	// Tests
	// ------------------------------------------------------------------

	task automatic test_directed();
		// one-byte chunk of 0xFF, empty size line ends the body,
		// then a byte past the end is dropped and closes the body
		body_bytes = '{8'h31, BYTE_CR, BYTE_LF, 8'hFF, BYTE_LF, BYTE_LF, 8'h00};
		send_body(0);
		// extension after ';', payload 00 and 80, then a non-hex digit that
		// folds to zero and so terminates
		body_bytes = '{8'h32, BYTE_SEMI, CH_X, BYTE_LF, 8'h00, 8'h80, BYTE_LF,
			8'h47, BYTE_LF};
		send_body(0);
		// nine digits: size wraps to 2, body clipped after one payload byte
		body_bytes = '{8'h46, CH_ZERO, CH_ZERO, CH_ZERO, CH_ZERO, CH_ZERO, CH_ZERO,
			CH_ZERO, 8'h32, BYTE_LF, 8'h5A};
		send_body(0);
	endtask

	task automatic test_random_traffic();
		idle_enable = 1'b1;
		send_mix(520);
	endtask

	// Long stretch with no idling on either side.
	task automatic test_back_to_back();
		idle_enable = 1'b0;
		send_mix(200);
		idle_enable = 1'b1;
	endtask

	// Receiver holds off while the sender keeps offering, so the pipe fills
	// and s_axis_tready drops.
	task automatic test_output_backpressure();
		idle_enable = 1'b0;
		hold_cycles = 60;
		send_mix(120);
		idle_enable = 1'b1;
	endtask

	initial begin
		repeat (2) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		test_directed();
		test_random_traffic();
		test_back_to_back();
		test_output_backpressure();
		s_axis_tvalid <= 1'b0;

		while (pending_results.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);

		if (error_count == 0)
			$display("RESULT: OK");
		else
			$display("RESULT: ERROR");
		$finish;
	end

	initial begin
		#(TIMEOUT);
		$display("RESULT: ERROR");
		$finish;
	end

endmodule
